// ===== rtl/rfa_pkg.sv =====
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types, constants and the exponential table for the radiative flux
// attenuation block.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int RFA_QUEUE_DEPTH = 2;
    localparam logic [31:0] EINV_Q32 = 32'd1580030169;

    // One cell as handed from the front end to the back end.
    typedef struct packed {
        logic        start;
        logic [31:0] flux;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
        logic [31:0] absorption;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_SCALE,
        ST_ACCUM,
        ST_EXP,
        ST_FLUX,
        ST_EMIT
    } t_back_state;

    typedef logic [31:0] t_exp_tab [32];

    // Integer square root of a 64-bit value, used only at elaboration.
    function automatic logic [63:0] isqrt_const(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 31; i >= 0; i--) begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // Entry j is exp(-2^(j-24)) in Q0.32.
    function automatic t_exp_tab build_exp_tab();
        logic [63:0] e [32];
        t_exp_tab    tab;
        e[24] = {32'd0, EINV_Q32};
        for (int j = 23; j >= 0; j--) begin
            e[j] = isqrt_const({e[j + 1][31:0], 32'd0});
        end
        for (int j = 25; j < 32; j++) begin
            e[j] = (e[j - 1] * e[j - 1]) >> 32;
        end
        for (int j = 0; j < 32; j++) begin
            tab[j] = e[j][31:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/radiative_flux_attenuation.sv =====
// The back end works on one cell at a time: the squaring, the 33-step bit-serial
// square root, the scaling, the accumulation and a walk over the 32 depth bits,
// and it takes the next cell from the queue only once its result is offered.
// The shared 32x32 multiplier and the root step serialise the work. Reset is
// synchronous and active low and returns depth, surface flux and previous
// point to zero.
// ----------------------------------------------------------------------------
// radiative_flux_attenuation
// Beer-Lambert attenuation of a surface radiative flux along columns of
// cells, with a front end and a back end joined by a short queue.
// ----------------------------------------------------------------------------
module radiative_flux_attenuation
    import rfa_pkg::*;
#(
    parameter int QUEUE_DEPTH = RFA_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // surface_flux, face_x, face_y, face_z, cell_x, cell_y, cell_z, absorption
    input  logic [255:0] i_s_axis_tdata,
    // column_start
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // cell_flux, depth_out
    output logic [63:0]  o_m_axis_tdata
);

    // The front end takes a transfer whenever the queue has room, so it keeps
    // classifying cells while the back end is still busy or a result waits.
    t_work     front_entry;
    t_work     back_entry;
    t_q_status q_status;
    logic      push;
    logic      pop;

    assign o_s_axis_tready = !q_status.full;

    rfa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_start (i_s_axis_tuser),
        .o_push  (push),
        .o_entry (front_entry)
    );

    rfa_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_work))
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_entry),
        .i_pop    (pop),
        .o_data   (back_entry),
        .o_status (q_status)
    );

    // The back end owns the optical depth and the start flux, and holds its
    // result in an output register until the downstream transfer.
    rfa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_entry    (back_entry),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_flux     (o_m_axis_tdata[31:0]),
        .o_depth    (o_m_axis_tdata[63:32])
    );

`ifndef ASSERT_OFF
    // An accepted cell is in the queue on the following cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !q_status.empty)
        else $error("accepted cell did not reach the queue");

    // The queue cannot be full and empty at once.
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");
`endif

endmodule

// ===== rtl/rfa_fifo.sv =====
// ----------------------------------------------------------------------------
// rfa_fifo
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rfa_fifo
    import rfa_pkg::*;
#(
    parameter int DEPTH = RFA_QUEUE_DEPTH,
    parameter int WIDTH = $bits(t_work)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_status.full  = (r_cnt == FULL);
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/rfa_front.sv =====
// ----------------------------------------------------------------------------
// rfa_front
// Accepts cells, handles column starts and forms the coordinate distances.
// ----------------------------------------------------------------------------
module rfa_front
    import rfa_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_ready,
    input  logic [255:0] i_data,
    input  logic         i_start,
    output logic         o_push,
    output t_work        o_entry
);

    logic [31:0] r_prev_x, r_prev_y, r_prev_z;
    logic [31:0] base_x, base_y, base_z;
    logic [31:0] flux_in, cell_x, cell_y, cell_z;

    function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? 32'(-d) : d[31:0];
    endfunction

    assign flux_in = i_data[31:0];
    assign cell_x  = i_data[159:128];
    assign cell_y  = i_data[191:160];
    assign cell_z  = i_data[223:192];

    // On a column start the face centre is the previous point.
    assign base_x = i_start ? i_data[63:32]  : r_prev_x;
    assign base_y = i_start ? i_data[95:64]  : r_prev_y;
    assign base_z = i_start ? i_data[127:96] : r_prev_z;

    assign o_push             = i_valid && i_ready;
    assign o_entry.start      = i_start;
    assign o_entry.flux       = flux_in[31] ? 32'd0 : flux_in;
    assign o_entry.dx         = abs_diff(cell_x, base_x);
    assign o_entry.dy         = abs_diff(cell_y, base_y);
    assign o_entry.dz         = abs_diff(cell_z, base_z);
    assign o_entry.absorption = i_data[255:224];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_prev_z <= '0;
        end else if (o_push) begin
            r_prev_x <= cell_x;
            r_prev_y <= cell_y;
            r_prev_z <= cell_z;
        end
    end

endmodule

// ===== rtl/rfa_back.sv =====
// ----------------------------------------------------------------------------
// rfa_back
// Sequencer for distance, optical depth and exponential attenuation, built
// around one shared 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module rfa_back
    import rfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_status   i_q_status,
    input  t_work       i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_flux,
    output logic [31:0] o_depth
);

    t_back_state r_state, n_state;
    t_work       r_work, n_work;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_phase, n_phase;
    logic [65:0] r_sum, n_sum;
    logic [35:0] r_rem, n_rem;
    logic [32:0] r_root, n_root;
    logic [63:0] r_prod;
    logic [31:0] r_depth, n_depth;
    logic [31:0] r_sflux, n_sflux;
    logic [31:0] r_m, n_m;
    logic        r_mone, n_mone;
    logic [31:0] r_res, n_res;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_oflux, n_oflux;
    logic [31:0] r_odepth, n_odepth;

    logic [31:0] mul_a, mul_b;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [52:0] inc;
    logic [53:0] dsum;
    logic [31:0] sq_op;
    logic        out_free;
    logic        last_bit;

    assign out_free = !r_ovalid || i_ready;
    assign last_bit = (r_cnt[4:0] == 5'd31);

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sq_op = r_work.dx;
            2'd1:    sq_op = r_work.dy;
            default: sq_op = r_work.dz;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (!i_q_status.empty) n_state = ST_SQUARE;
            ST_SQUARE: if (r_cnt == 6'd3) n_state = ST_ROOT;
            ST_ROOT:   if (r_cnt == 6'd32) n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_ACCUM;
            ST_ACCUM:  n_state = ST_EXP;
            ST_EXP: begin
                if (last_bit && (r_phase || !r_depth[r_cnt[4:0]] || r_mone)) begin
                    n_state = ST_FLUX;
                end
            end
            ST_FLUX:   if (r_phase || r_mone) n_state = ST_EMIT;
            ST_EMIT:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_work   = r_work;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_rem    = r_rem;
        n_root   = r_root;
        n_depth  = r_depth;
        n_sflux  = r_sflux;
        n_m      = r_m;
        n_mone   = r_mone;
        n_res    = r_res;
        n_ovalid = r_ovalid && !i_ready;
        n_oflux  = r_oflux;
        n_odepth = r_odepth;
        o_pop    = 1'b0;
        mul_a    = r_m;
        mul_b    = EXP_TAB[r_cnt[4:0]];
        rem_sh   = {r_rem[33:0], r_sum[65:64]};
        trial    = {1'b0, r_root, 2'b01};
        inc      = {1'b0, r_prod[63:12]} + (r_root[32] ? {1'b0, r_work.absorption, 20'd0}
                                                      : 53'd0);
        dsum     = {22'd0, r_depth} + {1'b0, inc};
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop  = 1'b1;
                    n_work = i_entry;
                    n_cnt  = '0;
                    n_sum  = '0;
                    if (i_entry.start) begin
                        n_depth = '0;
                        n_sflux = i_entry.flux;
                    end
                end
            end
            ST_SQUARE: begin
                mul_a = sq_op;
                mul_b = sq_op;
                if (r_cnt != 6'd0) begin
                    n_sum = r_sum + {2'd0, r_prod};
                end
                if (r_cnt == 6'd3) begin
                    n_cnt  = '0;
                    n_rem  = '0;
                    n_root = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ROOT: begin
                // One result bit per step, most significant pair first.
                if (rem_sh >= trial) begin
                    n_rem  = rem_sh - trial;
                    n_root = {r_root[31:0], 1'b1};
                end else begin
                    n_rem  = rem_sh;
                    n_root = {r_root[31:0], 1'b0};
                end
                n_sum = {r_sum[63:0], 2'b00};
                n_cnt = r_cnt + 1'b1;
            end
            ST_SCALE: begin
                mul_a = r_work.absorption;
                mul_b = r_root[31:0];
            end
            ST_ACCUM: begin
                n_depth = (dsum > 54'h0_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : dsum[31:0];
                n_cnt   = '0;
                n_phase = 1'b0;
                n_mone  = 1'b1;
            end
            ST_EXP: begin
                if (r_phase) begin
                    n_m     = r_prod[63:32];
                    n_phase = 1'b0;
                    n_cnt   = last_bit ? '0 : r_cnt + 1'b1;
                end else if (r_depth[r_cnt[4:0]] && !r_mone) begin
                    n_phase = 1'b1;
                end else begin
                    if (r_depth[r_cnt[4:0]]) begin
                        n_m    = EXP_TAB[r_cnt[4:0]];
                        n_mone = 1'b0;
                    end
                    n_cnt = last_bit ? '0 : r_cnt + 1'b1;
                end
            end
            ST_FLUX: begin
                mul_a = r_sflux;
                mul_b = r_m;
                if (r_mone) begin
                    n_res = r_sflux;
                end else if (r_phase) begin
                    n_res   = r_prod[63:32];
                    n_phase = 1'b0;
                end else begin
                    n_phase = 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oflux  = r_res;
                    n_odepth = r_depth;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_flux  = r_oflux;
    assign o_depth = r_odepth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_phase  <= 1'b0;
            r_depth  <= '0;
            r_sflux  <= '0;
            r_mone   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_phase  <= n_phase;
            r_depth  <= n_depth;
            r_sflux  <= n_sflux;
            r_mone   <= n_mone;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work   <= n_work;
        r_sum    <= n_sum;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_m      <= n_m;
        r_res    <= n_res;
        r_oflux  <= n_oflux;
        r_odepth <= n_odepth;
        r_prod   <= {32'd0, mul_a} * {32'd0, mul_b};
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for radiative_flux_attenuation. Columns of cells are streamed in
// bursts with random gaps. A behavioural model of the attenuation predicts
// the flux and depth of every cell, and the monitor checks each result
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import rfa_pkg::*;

    typedef struct packed {
        logic        start;
        logic [31:0] flux;
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] absorption;
    } t_cell;

    typedef struct packed {
        logic [31:0] flux;
        logic [31:0] depth;
    } t_atten;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;

    // Model state of the column walk.
    logic [63:0] exp_q32 [32];
    logic [31:0] column_depth;
    logic [31:0] column_flux;
    logic [31:0] prev_x;
    logic [31:0] prev_y;
    logic [31:0] prev_z;

    t_cell  pending_cells [$];
    t_atten expected_atten [$];
    int     error_count;
    bit     stimulus_done;
    bit     long_hold;
    bit     drain_pause;
    bit     s_fire;
    int     burst_left;
    int     gap_left;
    longint cycle_count;

    radiative_flux_attenuation u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Square root of a value up to 66 bits, held as hi:lo.
    function automatic logic [63:0] root66(logic [1:0] hi, logic [63:0] lo);
        logic [65:0] v;
        logic [67:0] rem;
        logic [67:0] trial;
        logic [63:0] root;
        v    = {hi, lo};
        rem  = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 66'd3);
            trial = ({4'd0, root} << 2) | 68'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic logic [63:0] abs_gap(logic [31:0] a, logic [31:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        return d < 0 ? 64'(-d) : 64'(d);
    endfunction

    task automatic build_exp_q32();
        exp_q32[24] = 64'd1580030169;
        for (int j = 23; j >= 0; j--)
            exp_q32[j] = root66(2'd0, {exp_q32[j + 1][31:0], 32'd0});
        for (int j = 25; j < 32; j++)
            exp_q32[j] = (exp_q32[j - 1] * exp_q32[j - 1]) >> 32;
    endtask

    // Advance the column by one cell and return its attenuated flux.
    function automatic t_atten attenuate(t_cell c);
        logic [63:0]  dx, dy, dz;
        logic [129:0] sq;
        logic [63:0]  distance;
        logic [95:0]  inc;
        logic [96:0]  sum;
        logic [63:0]  m;
        t_atten       r;
        if (c.start) begin
            column_flux  = c.flux[31] ? 32'd0 : c.flux;
            prev_x       = c.fx;
            prev_y       = c.fy;
            prev_z       = c.fz;
            column_depth = '0;
        end
        dx   = abs_gap(c.cx, prev_x);
        dy   = abs_gap(c.cy, prev_y);
        dz   = abs_gap(c.cz, prev_z);
        sq   = 130'(dx * dx) + 130'(dy * dy) + 130'(dz * dz);
        distance = root66(sq[65:64], sq[63:0]);
        inc  = (96'(c.absorption) * 96'(distance[32:0])) >> 12;
        sum  = 97'(column_depth) + 97'(inc);
        column_depth = sum > 97'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
        prev_x = c.cx;
        prev_y = c.cy;
        prev_z = c.cz;
        m = 64'd1 << 32;
        for (int j = 0; j < 32; j++)
            if (column_depth[j]) m = (m * exp_q32[j]) >> 32;
        r.flux  = 32'((64'(column_flux) * m) >> 32);
        r.depth = column_depth;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] rand_coord(int span);
        case ($urandom_range(0, 3))
            0: return $urandom();
            default: return 32'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    function automatic t_cell rand_cell(bit start, int span);
        t_cell c;
        c.start = start;
        c.flux  = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF);
        c.fx = rand_coord(span);
        c.fy = rand_coord(span);
        c.fz = rand_coord(span);
        c.cx = rand_coord(span);
        c.cy = rand_coord(span);
        c.cz = rand_coord(span);
        case ($urandom_range(0, 5))
            0: c.absorption = $urandom();
            1: c.absorption = '0;
            default: c.absorption = $urandom_range(0, 32'h0004_0000);
        endcase
        return c;
    endfunction

    // Directed cells, then random columns with a few stray cells.
    initial begin
        t_cell c;
        int n;
        build_exp_q32();
        error_count  = 0;
        column_depth = '0;
        column_flux  = '0;
        prev_x = '0;
        prev_y = '0;
        prev_z = '0;
        stimulus_done = 1'b0;
        drain_pause   = 1'b0;
        // A cell before any column start continues from the reset state.
        c = '0;
        c.cx = 32'h0010_0000; c.absorption = 32'h0001_0000;
        pending_cells.push_back(c);
        // Negative surface flux is clamped; extreme coordinates.
        c = '1;
        c.flux = 32'h8000_0000; c.fx = 32'h8000_0000; c.fy = 32'h8000_0000;
        c.fz = 32'h8000_0000; c.cx = 32'h7FFF_FFFF; c.cy = 32'h7FFF_FFFF;
        c.cz = 32'h7FFF_FFFF; c.absorption = 32'h0000_0001;
        pending_cells.push_back(c);
        // Largest flux, one metre of unit absorption: flux times 1/e.
        c = '0;
        c.start = 1'b1; c.flux = 32'h7FFF_FFFF; c.cz = 32'h0010_0000;
        c.absorption = 32'h0001_0000;
        pending_cells.push_back(c);
        c.start = 1'b0; c.cz = 32'h0020_0000;
        pending_cells.push_back(c);
        // Same point again adds nothing; zero absorption adds nothing.
        pending_cells.push_back(c);
        c.cz = 32'h0;
        c.absorption = '0;
        pending_cells.push_back(c);
        // Depth saturation, then very large depth drives the flux to zero.
        c.absorption = 32'hFFFF_FFFF; c.cx = 32'h7FFF_FFFF;
        pending_cells.push_back(c);
        c.cx = 32'h8000_0000;
        pending_cells.push_back(c);
        // Depth in the few-units range where the flux is small but non-zero.
        c = '0;
        c.start = 1'b1; c.flux = 32'h00FF_FF00; c.cx = 32'h0080_0000;
        c.absorption = 32'h0002_0000;
        pending_cells.push_back(c);
        c.start = 1'b0; c.cx = 32'h0100_0000;
        pending_cells.push_back(c);
        c.start = 1'b1; c.flux = 32'h0; c.absorption = 32'hFFFF_FFFF;
        pending_cells.push_back(c);
        for (int k = 0; k < 8; k++) pending_cells.push_back(rand_cell($urandom_range(0, 1), 1 << 20));

        while (pending_cells.size() != 0 || expected_atten.size() != 0) @(posedge i_clk);
        // Sender paused while the random cells are queued.
        drain_pause = 1'b1;
        n = 0;
        while (n < 400) begin
            int len;
            len = $urandom_range(1, 12);
            for (int k = 0; k < len && n < 400; k++) begin
                pending_cells.push_back(rand_cell(k == 0, 1 << $urandom_range(8, 26)));
                n++;
            end
            if ($urandom_range(0, 9) == 0) begin
                pending_cells.push_back(rand_cell(1'b0, 1 << 30));
                n++;
            end
        end
        drain_pause = 1'b0;
        stimulus_done = 1'b1;
    end

    // Reset and the end of the run.
    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stimulus_done && pending_cells.size() == 0 && expected_atten.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // The input handshake is decided at the rising edge.
    always @(posedge i_clk) s_fire <= s_tvalid && s_tready;

    // Driver: bursts of transfers with random gaps, fed from pending_cells.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            burst_left <= $urandom_range(1, 20);
            gap_left   <= 0;
        end else if (!(s_tvalid && !s_fire)) begin
            if (gap_left > 0 || drain_pause || pending_cells.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                t_cell c;
                c = pending_cells.pop_front();
                expected_atten.push_back(attenuate(c));
                s_tvalid <= 1'b1;
                s_tuser  <= c.start;
                s_tdata  <= {c.absorption, c.cz, c.cy, c.cx, c.fz, c.fy, c.fx, c.flux};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold-off early in the random part.
    initial begin
        long_hold = 1'b0;
        wait (stimulus_done);
        repeat (50) @(posedge i_clk);
        long_hold = 1'b1;
        repeat (2000) @(posedge i_clk);
        long_hold = 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) m_tready <= 1'b0;
        else if (long_hold) m_tready <= 1'b0;
        else if (cycle_count[11:9] == 3'd5) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor and timeout.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (cycle_count > 1_500_000) begin
                $display("simulation failed");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (expected_atten.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
                end else begin
                    t_atten w;
                    w = expected_atten.pop_front();
                    if (m_tdata[31:0] !== w.flux) report_mismatch("cell_flux", m_tdata[31:0], w.flux);
                    if (m_tdata[63:32] !== w.depth)
                        report_mismatch("depth_out", m_tdata[63:32], w.depth);
                end
            end
        end
    end
endmodule
